>>> design/ptbd_pkg.sv
// Package for the point-to-box distance unit: shared widths, constants and the
// command and status structs between the controller and the datapath.
// No dependencies.
package ptbd_pkg;

	// Width of one coordinate field as it travels on the stream.
	localparam int FIELD_W    = 32;
	localparam int IN_DATA_W  = 3 * FIELD_W;
	localparam int OUT_DATA_W = FIELD_W;

	// Accumulator and square-root datapath widths.
	localparam int ACC_W      = 64;
	localparam int ROOT_W     = ACC_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam int ROOT_STEPS = ROOT_W;
	localparam int CNT_W      = $clog2(ROOT_STEPS);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;   // capture the accepted item
		logic sel_upper;   // 0: lower bound check, 1: upper bound check
		logic calc_exc;    // register the excess for the selected bound
		logic calc_mul;    // register the excess or its square
		logic calc_acc;    // saturating add into the running sum
		logic root_start;  // load the running sum into the root unit
		logic root_step;   // one digit of the square root
		logic emit;        // load the output register and clear the sum
	} ptbd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;        // the captured item ends the point
		logic mode;        // captured distance mode, 1 for Euclidean
		logic out_free;    // the output register can take a result now
	} ptbd_status_t;

endpackage

>>> design/ptbd_ctrl.sv
// Controller state machine of the point-to-box distance unit.
// Sequences the datapath through both bound checks, the square root in Euclidean mode and the emit.
// Depends on ptbd_pkg.
module ptbd_ctrl import ptbd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  ptbd_status_t status,
	output ptbd_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXC   = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_ACC   = 3'd3;
	localparam logic [2:0] ST_RINIT = 3'd4;
	localparam logic [2:0] ST_ROOT  = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0]       state_q, state_d;
	logic             sel_q, sel_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	// Next-state and command decode.
	always_comb begin
		state_d  = state_q;
		sel_d    = sel_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		s_tready = 1'b0;
		cmd.sel_upper = sel_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					sel_d   = 1'b0;
					state_d = ST_EXC;
				end
			end
			ST_EXC: begin
				cmd.calc_exc = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.calc_mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.calc_acc = 1'b1;
				if (!sel_q) begin
					sel_d   = 1'b1;
					state_d = ST_EXC;
				end else if (!status.last) begin
					state_d = ST_IDLE;
				end else if (status.mode) begin
					state_d = ST_RINIT;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_RINIT: begin
				cmd.root_start = 1'b1;
				cnt_d   = '0;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

>>> design/ptbd_dp.sv
// Datapath of the point-to-box distance unit: excess, square, saturating
// accumulator, digit-serial square root and the output register.
// Depends on ptbd_pkg.
module ptbd_dp import ptbd_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tlast,
	input  logic                  m_tready,
	output logic                  m_tvalid,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tuser,
	input  ptbd_cmd_t             cmd,
	output ptbd_status_t          status
);

	localparam int VW = VALUE_WIDTH;
	localparam logic [OUT_DATA_W-1:0] MAX_DIST =
		OUT_DATA_W'((64'd1 << VALUE_WIDTH) - 64'd1);

	logic                  mode_cfg_q;
	logic [VW-1:0]         coord_q, lower_q, upper_q;
	logic                  last_q, mode_q;
	logic [VW-1:0]         excess_q;
	logic [ACC_W-1:0]      prod_q;
	logic [ACC_W-1:0]      acc_q;
	logic                  ovf_q;
	logic [ACC_W-1:0]      rv_q;
	logic [ROOT_W-1:0]     root_q;
	logic [REM_W-1:0]      rem_q;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_dist_q;
	logic                  out_sat_q;

	// Excess for the selected bound, with one guard bit for the difference.
	logic signed [VW:0] c_ext, lo_ext, hi_ext, diff;
	logic               outside;
	logic [VW-1:0]      excess_d;

	always_comb begin
		c_ext  = {coord_q[VW-1], coord_q};
		lo_ext = {lower_q[VW-1], lower_q};
		hi_ext = {upper_q[VW-1], upper_q};
		if (cmd.sel_upper) begin
			outside = c_ext > hi_ext;
			diff    = c_ext - hi_ext;
		end else begin
			outside = c_ext < lo_ext;
			diff    = lo_ext - c_ext;
		end
		excess_d = outside ? diff[VW-1:0] : '0;
	end

	// Square or plain excess, and the saturating accumulation.
	logic [2*VW-1:0]  square;
	logic [ACC_W-1:0] prod_d;
	logic [ACC_W:0]   acc_sum;

	assign square  = excess_q * excess_q;
	assign prod_d  = mode_q ? ACC_W'(square) : ACC_W'(excess_q);
	assign acc_sum = {1'b0, acc_q} + {1'b0, prod_q};

	// One digit of the restoring square root.
	logic [REM_W+1:0] rem_shift, trial;
	logic             take;

	assign rem_shift = {rem_q, rv_q[ACC_W-1 -: 2]};
	assign trial     = (REM_W + 2)'({root_q, 2'b01});
	assign take      = rem_shift >= trial;

	// Result selection and clip to the value width.
	logic [ACC_W-1:0] dist_full;
	logic             clip;

	assign dist_full = mode_q ? ACC_W'(root_q) : acc_q;
	assign clip      = |dist_full[ACC_W-1:VALUE_WIDTH];

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_cfg_q <= 1'b0;
		end else if (cfg_we) begin
			mode_cfg_q <= cfg_wdata;
		end
	end

	// Item capture and working registers.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			coord_q <= s_tdata[VW-1:0];
			lower_q <= s_tdata[FIELD_W +: VW];
			upper_q <= s_tdata[2*FIELD_W +: VW];
			last_q  <= s_tlast;
			mode_q  <= mode_cfg_q;
		end
		if (cmd.calc_exc) begin
			excess_q <= excess_d;
		end
		if (cmd.calc_mul) begin
			prod_q <= prod_d;
		end
		if (cmd.root_start) begin
			rv_q   <= acc_q;
			root_q <= '0;
			rem_q  <= '0;
		end else if (cmd.root_step) begin
			rv_q <= {rv_q[ACC_W-3:0], 2'b00};
			if (take) begin
				rem_q  <= REM_W'(rem_shift - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= REM_W'(rem_shift);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.emit) begin
			out_dist_q <= clip ? MAX_DIST : dist_full[OUT_DATA_W-1:0];
			out_sat_q  <= ovf_q | clip;
		end
	end

	// Running sum and overflow flag, cleared when a result is written to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.emit) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.calc_acc) begin
			if (acc_sum[ACC_W]) begin
				acc_q <= '1;
				ovf_q <= 1'b1;
			end else begin
				acc_q <= acc_sum[ACC_W-1:0];
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid        = out_valid_q;
	assign m_tdata         = out_dist_q;
	assign m_tuser         = out_sat_q;
	assign status.last     = last_q;
	assign status.mode     = mode_q;
	assign status.out_free = !out_valid_q || m_tready;

endmodule

>>> design/point_to_box_distance_unit.sv
// The unit measures how far a point lies outside an axis-aligned box, one
// dimension per item, in signed fixed point with the low VALUE_WIDTH bits of
// each field significant. Each item is checked against its lower and its upper
// bound in turn through one shared excess, square and saturating-accumulate
// path, and the input stays closed until the item is through. After the item
// marked with tlast, L1 mode emits the sum, and Euclidean mode first runs a
// digit-serial square root that takes one result bit per cycle. The result waits
// in an output register, so the next point is taken while it is unread.
// Depends on ptbd_pkg, ptbd_ctrl and ptbd_dp.
module point_to_box_distance_unit import ptbd_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration: distance_mode, 0 for L1, 1 for Euclidean.
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // coordinate, lower_bound, upper_bound
	input  logic                  s_tlast,   // last_dimension
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // distance
	output logic                  m_tuser    // saturated
);

	ptbd_cmd_t    cmd;
	ptbd_status_t status;

	ptbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ptbd_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.status    (status)
	);

	// A result is only written into a free output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid || m_tready))
		else $error("result written over an unread result");

	// A written result shows on the output in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid)
		else $error("written result not presented");

	// An accepted item keeps the input closed while it is processed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input reopened during item processing");

endmodule
